FILE: rtl/pgki_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pgki_pkg;

   localparam int PARTICLE_COUNT = 4096;
   localparam int PART_W         = $clog2(PARTICLE_COUNT);
   localparam int ANGLE_STEPS    = 1024;
   localparam int ANGLE_W        = $clog2(ANGLE_STEPS);
   localparam int KICK_SCALE     = 918;   // 0.014 in Q16.16

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_GRAVITY_X    = 3'd0,
      CSR_GRAVITY_Y    = 3'd1,
      CSR_GRAVITY_Z    = 3'd2,
      CSR_ATTENUATION  = 3'd3,
      CSR_FRICTION     = 3'd4,
      CSR_GROUND_LEVEL = 3'd5
   } csr_index_type;

   localparam logic signed [31:0] GRAVITY_Z_RST    = -32'sd642908;
   localparam logic        [16:0] ATTENUATION_RST  = 17'd65536;
   localparam logic        [16:0] FRICTION_RST     = 17'd65431;
   localparam logic signed [31:0] GROUND_LEVEL_RST = -32'sd524288;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_STEP = 1'b1
   } mode_type;

   typedef struct packed {
      logic               mode;
      logic [11:0]        particle;
      logic signed [31:0] load_x;
      logic signed [31:0] load_y;
      logic signed [31:0] load_z;
      logic [15:0]        load_mass;
      logic [15:0]        time_step;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
      logic [9:0]         kick_angle;
      logic [9:0]         kick_amount;
   } req_type;

   typedef struct packed {
      logic [11:0]        particle_out;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               grounded;
   } rsp_type;

   // one particle table entry
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [1:0][31:0] kick;
      logic [15:0]      mass;
      logic             flag;
   } entry_type;

   typedef logic signed [15:0] trig_arr_type [ANGLE_STEPS];

   function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -36'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   // sin(u/16384 * pi/2) in Q2.14, Taylor series in Q30
   function automatic logic [63:0] quarter_sine(input logic [63:0] u);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = u * 64'd102944;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
      return (((x * t) >> 30) + 64'd32768) >> 16;
   endfunction

   function automatic logic signed [15:0] phase_sine(input logic [31:0] p);
      logic [15:0] pp;
      logic [1:0]  q;
      logic [63:0] r;
      logic [63:0] m;
      pp = p[15:0];
      q  = pp[15:14];
      r  = 64'(pp[13:0]);
      m  = q[0] ? quarter_sine(64'd16384 - r) : quarter_sine(r);
      return q[1] ? -$signed(m[15:0]) : $signed(m[15:0]);
   endfunction

   function automatic trig_arr_type trig_build(input logic cos_sel);
      trig_arr_type t;
      logic [31:0]  p;
      for (int a = 0; a < ANGLE_STEPS; a++) begin
         p = 32'((64'(a) << 16) / ANGLE_STEPS);
         t[a] = phase_sine(cos_sel ? p + 32'd16384 : p);
      end
      return t;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/particle_ground_kick_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// A taken start passes pipeline stages 1 to 5 and then the output register before
// its word appears on rsp_. Throughput: one word per cycle; busy rises only while
// the addressed particle is still in flight in the 5-stage read-modify-write pipeline.
// Reset: synchronous; clears the pipeline and loads the register defaults.
// The particle table holds garbage until loaded. The receiver cannot stall.
module particle_ground_kick_integrator import pgki_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam trig_arr_type COS_TAB = trig_build(1'b1);
   localparam trig_arr_type SIN_TAB = trig_build(1'b0);

   // configuration
   logic signed [31:0] grav_ff [3];
   logic        [16:0] atten_ff, fric_ff;
   logic signed [31:0] ground_ff;
   logic        [17:0] factor_ff;
   logic        [33:0] factor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff[0] <= '0;
         grav_ff[1] <= '0;
         grav_ff[2] <= GRAVITY_Z_RST;
         atten_ff   <= ATTENUATION_RST;
         fric_ff    <= FRICTION_RST;
         ground_ff  <= GROUND_LEVEL_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRAVITY_X:    grav_ff[0] <= csr_wdata;
            CSR_GRAVITY_Y:    grav_ff[1] <= csr_wdata;
            CSR_GRAVITY_Z:    grav_ff[2] <= csr_wdata;
            CSR_ATTENUATION:  atten_ff   <= csr_wdata[16:0];
            CSR_FRICTION:     fric_ff    <= csr_wdata[16:0];
            CSR_GROUND_LEVEL: ground_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // combined damping factor, kept registered
   always_comb factor_in = 34'(atten_ff) * 34'(fric_ff) + 34'd32768;
   always_ff @(posedge clock) begin
      factor_ff <= factor_in[33:16];
   end

   // pipeline control
   logic [5:1] vld_ff;
   req_type    req_ff [1:5];
   logic       accept;

   always_comb begin
      busy = 1'b0;
      for (int i = 1; i <= 5; i++) begin
         if (vld_ff[i] && req_ff[i].particle == req_data.particle) busy = 1'b1;
      end
   end
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:1], accept};
      end
   end

   always_ff @(posedge clock) begin
      req_ff[1] <= req_data;
      for (int i = 2; i <= 5; i++) req_ff[i] <= req_ff[i-1];
   end

   // particle table and trig ROM, read at accept
   entry_type          mem [PARTICLE_COUNT];
   entry_type          rd_ff;
   logic               wr_en;
   entry_type          wr_data;
   entry_type          wr_word;
   logic signed [15:0] cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[req_ff[5].particle] <= wr_word;
      if (accept) begin
         rd_ff  <= mem[req_data.particle];
         cos_ff <= COS_TAB[req_data.kick_angle];
         sin_ff <= SIN_TAB[req_data.kick_angle];
      end
   end

   // stage 1: mass*dt, velocity sums, kick amplitude
   logic signed [31:0] move1 [3];
   logic signed [33:0] vsum_in [3];
   logic signed [33:0] vsum2_ff [3];
   logic        [31:0] mdt2_ff;
   logic        [19:0] amp2_ff;
   logic signed [15:0] cos2_ff, sin2_ff;
   logic [2:0][31:0]   pos2_ff;
   logic               flag2_ff;

   always_comb begin
      move1[0] = req_ff[1].move_x;
      move1[1] = req_ff[1].move_y;
      move1[2] = req_ff[1].move_z;
      for (int k = 0; k < 3; k++) begin
         vsum_in[k] = 34'($signed(rd_ff.vel[k])) + 34'(move1[k])
                    + ((k < 2) ? 34'($signed(rd_ff.kick[k[0]])) : 34'sd0);
      end
   end

   always_ff @(posedge clock) begin
      vsum2_ff <= vsum_in;
      mdt2_ff  <= 32'(rd_ff.mass) * 32'(req_ff[1].time_step);
      amp2_ff  <= 20'(KICK_SCALE) * 20'(req_ff[1].kick_amount);
      cos2_ff  <= cos_ff;
      sin2_ff  <= sin_ff;
      pos2_ff  <= rd_ff.pos;
      flag2_ff <= rd_ff.flag;
   end

   // stage 2: gravity and kick products
   logic signed [64:0] gp3_ff [3];
   logic signed [36:0] kp3_ff [2];
   logic signed [33:0] vsum3_ff [3];
   logic [2:0][31:0]   pos3_ff;
   logic               flag3_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         gp3_ff[k] <= 65'(grav_ff[k]) * $signed({33'd0, mdt2_ff});
      end
      kp3_ff[0] <= $signed({17'd0, amp2_ff}) * 37'(cos2_ff);
      kp3_ff[1] <= $signed({17'd0, amp2_ff}) * 37'(sin2_ff);
      vsum3_ff  <= vsum2_ff;
      pos3_ff   <= pos2_ff;
      flag3_ff  <= flag2_ff;
   end

   // stage 3: round, add gravity term, saturate; round kick
   logic signed [64:0] gr_in [3];
   logic signed [36:0] kr_in [2];
   logic signed [31:0] vp4_ff [3];
   logic signed [31:0] kick4_ff [2];
   logic [2:0][31:0]   pos4_ff;
   logic               flag4_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) gr_in[k] = gp3_ff[k] + 65'sd2147483648;
      for (int k = 0; k < 2; k++) kr_in[k] = kp3_ff[k] + 37'sd8388608;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         vp4_ff[k] <= sat36(36'(vsum3_ff[k]) + 36'($signed(gr_in[k][64:32])));
      end
      for (int k = 0; k < 2; k++) kick4_ff[k] <= 32'($signed(kr_in[k][36:24]));
      pos4_ff  <= pos3_ff;
      flag4_ff <= flag3_ff;
   end

   // stage 4: damping product
   logic signed [50:0] vm5_ff [3];
   logic signed [31:0] kick5_ff [2];
   logic [2:0][31:0]   pos5_ff;
   logic               flag5_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         vm5_ff[k] <= 51'(vp4_ff[k]) * $signed({33'd0, factor_ff});
      end
      kick5_ff <= kick4_ff;
      pos5_ff  <= pos4_ff;
      flag5_ff <= flag4_ff;
   end

   // stage 5: velocity, position, ground contact, write back
   logic signed [50:0] vr [3];
   logic signed [31:0] vn [3];
   logic signed [31:0] pn [3];
   rsp_type            rsp_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vr[k] = vm5_ff[k] + 51'sd32768;
         vn[k] = sat36(36'($signed(vr[k][50:16])));
         pn[k] = sat36(36'($signed(pos5_ff[k])) + 36'(vn[k]));
      end
      wr_en = vld_ff[5];
      rsp_in.particle_out = req_ff[5].particle;
      if (req_ff[5].mode == MODE_LOAD) begin
         wr_data.pos[0] = req_ff[5].load_x;
         wr_data.pos[1] = req_ff[5].load_y;
         wr_data.pos[2] = req_ff[5].load_z;
         wr_data.vel    = '0;
         wr_data.kick   = '0;
         wr_data.mass   = req_ff[5].load_mass;
         wr_data.flag   = 1'b0;
      end else begin
         wr_data.pos[0] = pn[0];
         wr_data.pos[1] = pn[1];
         wr_data.pos[2] = pn[2];
         wr_data.vel[0] = vn[0];
         wr_data.vel[1] = vn[1];
         wr_data.vel[2] = vn[2];
         wr_data.kick   = '0;
         wr_data.mass   = req_ff[5].load_mass;
         wr_data.flag   = flag5_ff;
         // ground contact: clamp z, kick only on first touch
         if (pn[2] <= ground_ff) begin
            wr_data.pos[2] = ground_ff;
            wr_data.flag   = 1'b1;
            if (!flag5_ff) begin
               wr_data.kick[0] = kick5_ff[0];
               wr_data.kick[1] = kick5_ff[1];
            end
         end
      end
      rsp_in.pos_x    = wr_data.pos[0];
      rsp_in.pos_y    = wr_data.pos[1];
      rsp_in.pos_z    = wr_data.pos[2];
      rsp_in.grounded = wr_data.flag;
   end

   // mass is unchanged by a step: carry it from the table read
   logic [15:0] mass_ff [2:5];
   always_ff @(posedge clock) begin
      mass_ff[2] <= rd_ff.mass;
      for (int i = 3; i <= 5; i++) mass_ff[i] <= mass_ff[i-1];
   end

   always_comb begin
      wr_word = wr_data;
      if (req_ff[5].mode == MODE_STEP) wr_word.mass = mass_ff[5];
   end

   // output register
   logic    strobe_ff;
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[5];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire
